// ===== rtl/core/hmtri_pkg.sv =====
// Package for the heightmap triangle height query block.
// Holds the request and result field widths and the opcode codes.
// No dependencies.
package hmtri_pkg;

	// Field widths of one request and one result.
	localparam int OPCODE_W = 2;
	localparam int INDEX_W  = 8;
	localparam int HIN_W    = 32;
	localparam int POS_W    = 24;
	localparam int HOUT_W   = 32;

	// Stream bus widths: tdata holds grid_row, grid_col, height_in, query_x, query_z.
	localparam int S_TDATA_W = 2 * INDEX_W + HIN_W + 2 * POS_W;
	localparam int M_TDATA_W = HOUT_W;

	// Opcodes carried in tuser.
	typedef logic [OPCODE_W-1:0] opcode_t;
	localparam opcode_t OP_WR_CENTER = 2'd0;
	localparam opcode_t OP_WR_CORNER = 2'd1;
	localparam opcode_t OP_QUERY     = 2'd2;

	// Unpacked view of one request.
	typedef struct packed {
		logic [POS_W-1:0]   query_z;
		logic [POS_W-1:0]   query_x;
		logic [HIN_W-1:0]   height_in;
		logic [INDEX_W-1:0] grid_col;
		logic [INDEX_W-1:0] grid_row;
	} req_t;

endpackage

// ===== rtl/core/heightmap_triangle_height_query.sv =====
// Heightmap triangle height query: center and corner height grids in two
// synchronous memories, each with a write port and a registered read port, and a sequencer that interpolates a height.
// Depends on hmtri_pkg.
// Writes are taken while the sequencer is idle. A query runs as two corner reads in
// turn on the corner memory port, an operand step, a multiply step and a sum step; the
// result is loaded into the output register in the sum step once that register is free.
// Reset clears the sequencer and the output valid; memory contents stay undefined.
module heightmap_triangle_height_query #(
	parameter int GRID_CELLS  = 128,
	parameter int FRAC_BITS   = 16,
	parameter int HEIGHT_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Request stream.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// s_tdata from bit 0 up: grid_row, grid_col, height_in, query_x, query_z.
	input  logic [hmtri_pkg::S_TDATA_W-1:0] s_tdata,
	// s_tuser: opcode.
	input  logic [hmtri_pkg::OPCODE_W-1:0]  s_tuser,
	// Result stream.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// m_tdata: height_out.
	output logic [hmtri_pkg::M_TDATA_W-1:0] m_tdata
);

	localparam int H      = HEIGHT_BITS;
	localparam int PW     = hmtri_pkg::POS_W;
	localparam int OW     = PW + 2;
	localparam int CSIDE  = GRID_CELLS + 1;
	localparam int CDEPTH = GRID_CELLS * GRID_CELLS;
	localparam int KDEPTH = CSIDE * CSIDE;
	localparam int XW     = $clog2(GRID_CELLS);
	localparam int CW     = $clog2(CDEPTH);
	localparam int KW     = $clog2(KDEPTH);
	localparam int ACCW   = H + OW + 3;

	localparam logic [PW-1:0]          LAST_CELL = PW'(GRID_CELLS - 1);
	localparam logic [PW:0]            ONE_U     = (PW + 1)'(1) << FRAC_BITS;
	localparam logic signed [OW-1:0]   ONE_W     = OW'(1) << FRAC_BITS;
	localparam logic signed [ACCW-1:0] MAX_H     = (ACCW'(1) <<< (H - 1)) - ACCW'(1);
	localparam logic signed [ACCW-1:0] MIN_H     = -(ACCW'(1) <<< (H - 1));

	// Sequencer states.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RDB  = 3'd1;
	localparam logic [2:0] ST_OPS  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_SUM  = 3'd4;

	logic [2:0] state_q;

	hmtri_pkg::req_t    req;
	hmtri_pkg::opcode_t opcode;
	logic               accept;

	assign req      = hmtri_pkg::req_t'(s_tdata);
	assign opcode   = hmtri_pkg::opcode_t'(s_tuser);
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Memories.
	logic [H-1:0] center_mem [0:CDEPTH-1];
	logic [H-1:0] corner_mem [0:KDEPTH-1];
	logic [H-1:0] center_rd_q;
	logic [H-1:0] corner_rd_q;

	// Write decode: range check, address and height taken as H-bit two's complement.
	logic              center_we;
	logic              corner_we;
	logic [CW-1:0]     center_waddr;
	logic [KW-1:0]     corner_waddr;
	logic [H+31:0]     hin_ext;
	logic [H-1:0]      hin;

	always_comb begin
		hin_ext      = {{H{1'b0}}, req.height_in};
		hin          = hin_ext[H-1:0];
		center_we    = accept && (opcode == hmtri_pkg::OP_WR_CENTER) &&
		               (int'(req.grid_row) < GRID_CELLS) && (int'(req.grid_col) < GRID_CELLS);
		corner_we    = accept && (opcode == hmtri_pkg::OP_WR_CORNER) &&
		               (int'(req.grid_row) <= GRID_CELLS) && (int'(req.grid_col) <= GRID_CELLS);
		center_waddr = CW'(CW'(req.grid_row) * CW'(GRID_CELLS) + CW'(req.grid_col));
		corner_waddr = KW'(KW'(req.grid_row) * KW'(CSIDE) + KW'(req.grid_col));
	end

	// Query decode: cell index with clamping, in-cell offsets and triangle choice.
	logic [PW-1:0]        xc_full, zc_full;
	logic [XW-1:0]        xc, zc;
	logic [PW-1:0]        lx, lz;
	logic                 tri_hi_x, tri_far;
	logic [CW-1:0]        center_raddr;
	logic [KW-1:0]        a_addr, b_addr;
	logic [KW-1:0]        corner_raddr;
	logic signed [OW-1:0] u_c, w_c;
	logic [KW-1:0]        k00, k10, k01, k11;

	always_comb begin
		xc_full  = req.query_x >> FRAC_BITS;
		zc_full  = req.query_z >> FRAC_BITS;
		xc       = (xc_full > LAST_CELL) ? XW'(LAST_CELL) : XW'(xc_full);
		zc       = (zc_full > LAST_CELL) ? XW'(LAST_CELL) : XW'(zc_full);
		lx       = req.query_x - (PW'(xc) << FRAC_BITS);
		lz       = req.query_z - (PW'(zc) << FRAC_BITS);
		tri_hi_x = (lx > lz);
		tri_far  = ((PW + 1)'(lx) + (PW + 1)'(lz)) > ONE_U;

		center_raddr = CW'(CW'(xc) * CW'(GRID_CELLS) + CW'(zc));
		k00 = KW'(KW'(xc) * KW'(CSIDE) + KW'(zc));
		k01 = KW'(k00 + KW'(1));
		k10 = KW'(k00 + KW'(CSIDE));
		k11 = KW'(k10 + KW'(1));

		// Every triangle: base A, da = B - A, db = A + B - 2c with a signed weight w.
		if (tri_hi_x && tri_far) begin
			a_addr = k10; b_addr = k11;
			u_c = OW'(lz); w_c = $signed(OW'(lx)) - ONE_W;
		end else if (tri_hi_x) begin
			a_addr = k00; b_addr = k10;
			u_c = OW'(lx); w_c = -$signed(OW'(lz));
		end else if (tri_far) begin
			a_addr = k01; b_addr = k11;
			u_c = OW'(lx); w_c = $signed(OW'(lz)) - ONE_W;
		end else begin
			a_addr = k00; b_addr = k01;
			u_c = OW'(lz); w_c = -$signed(OW'(lx));
		end
	end

	logic [KW-1:0] b_addr_q;

	assign corner_raddr = (state_q == ST_RDB) ? b_addr_q : a_addr;

	// Center memory: one write and one read a cycle, registered read data.
	always_ff @(posedge clk) begin
		if (center_we) begin
			center_mem[center_waddr] <= hin;
		end
		center_rd_q <= center_mem[center_raddr];
	end

	// Corner memory: the two corners of a triangle are read in consecutive cycles.
	always_ff @(posedge clk) begin
		if (corner_we) begin
			corner_mem[corner_waddr] <= hin;
		end
		corner_rd_q <= corner_mem[corner_raddr];
	end

	// Datapath registers.
	logic signed [OW-1:0]    u_q, w_q;
	logic signed [H-1:0]     ha_q, c_q, base_q, base2_q;
	logic signed [H:0]       da_q;
	logic signed [H+1:0]     db_q;
	logic signed [H+OW:0]    p1_q;
	logic signed [H+OW+1:0]  p2_q;
	logic [H-1:0]            out_q;
	logic                    out_valid_q;

	logic signed [H-1:0]     hb;
	logic signed [ACCW-1:0]  base_ext, acc, fl, sat;
	logic                    out_free;

	assign hb       = corner_rd_q;
	assign out_free = !out_valid_q || m_tready;

	// Final sum, floor by the fraction shift, and saturation to the height range.
	always_comb begin
		base_ext = base2_q;
		acc      = (base_ext <<< FRAC_BITS) + p1_q + p2_q;
		fl       = acc >>> FRAC_BITS;
		if (fl > MAX_H) begin
			sat = MAX_H;
		end else if (fl < MIN_H) begin
			sat = MIN_H;
		end else begin
			sat = fl;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				b_addr_q <= b_addr;
				u_q      <= u_c;
				w_q      <= w_c;
			end
			ST_RDB: begin
				ha_q <= corner_rd_q;
				c_q  <= center_rd_q;
			end
			ST_OPS: begin
				base_q <= ha_q;
				da_q   <= hb - ha_q;
				db_q   <= ha_q + hb - c_q - c_q;
			end
			ST_MUL: begin
				p1_q    <= da_q * u_q;
				p2_q    <= db_q * w_q;
				base2_q <= base_q;
			end
			ST_SUM: begin
				if (out_free) begin
					out_q <= sat[H-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// The output valid rises when a result is loaded and falls when it is taken.
			if ((state_q == ST_SUM) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && (opcode == hmtri_pkg::OP_QUERY)) begin
						state_q <= ST_RDB;
					end
				end
				ST_RDB:  state_q <= ST_OPS;
				ST_OPS:  state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_SUM;
				ST_SUM: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result: the H-bit height, zero-extended or cut to the output width.
	logic [H+31:0] out_ext;

	assign out_ext  = {32'b0, out_q};
	assign m_tdata  = out_ext[hmtri_pkg::M_TDATA_W-1:0];
	assign m_tvalid = out_valid_q;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for heightmap_triangle_height_query.
// Drives write and query requests over the stream bus and predicts each height.
// Depends on hmtri_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_top;

	localparam int GRID_CELLS   = 128;
	localparam int CORNER_SIDE  = GRID_CELLS + 1;
	localparam int FRAC_BITS    = 16;
	localparam int HEIGHT_BITS  = 32;
	localparam int PHASE_ITEMS  = 420;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_LIMIT  = 5000;
	localparam int INDEX_W      = hmtri_pkg::INDEX_W;
	localparam int POS_W        = hmtri_pkg::POS_W;
	localparam int HIN_W        = hmtri_pkg::HIN_W;
	localparam int HOUT_W       = hmtri_pkg::HOUT_W;
	localparam longint UNIT       = longint'(1) << FRAC_BITS;
	localparam longint HEIGHT_MAX = (longint'(1) << (HEIGHT_BITS - 1)) - 1;
	localparam longint HEIGHT_MIN = -(longint'(1) << (HEIGHT_BITS - 1));
	// The fourth opcode value has no function in the block.
	localparam hmtri_pkg::opcode_t OP_UNUSED = 2'd3;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [hmtri_pkg::S_TDATA_W-1:0] s_tdata;
	logic [hmtri_pkg::OPCODE_W-1:0]  s_tuser;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [hmtri_pkg::M_TDATA_W-1:0] m_tdata;

	// Predicted contents of both height grids.
	logic signed [HIN_W-1:0] center_store [GRID_CELLS * GRID_CELLS];
	logic signed [HIN_W-1:0] corner_store [CORNER_SIDE * CORNER_SIDE];
	// Cells whose center and four corners have all been written.
	bit                      cell_ready   [GRID_CELLS * GRID_CELLS];
	int                      ready_cells  [$];

	logic [HOUT_W-1:0] expected_heights [$];
	int unsigned       height_errors;
	int unsigned       send_idle_pct;
	int unsigned       recv_stall_pct;
	logic              result_hold;

	heightmap_triangle_height_query dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Height of the triangle plane at a query position, floored and saturated.
	function automatic logic [HOUT_W-1:0] predict_height(logic [POS_W-1:0] qx,
			logic [POS_W-1:0] qz);
		longint xc, zc, lx, lz, c, h00, h10, h01, h11, base, da, db, u, w, acc;
		xc = qx >> FRAC_BITS;
		zc = qz >> FRAC_BITS;
		if (xc > GRID_CELLS - 1)
			xc = GRID_CELLS - 1;
		if (zc > GRID_CELLS - 1)
			zc = GRID_CELLS - 1;
		// Offsets run past one cell when the index was clamped.
		lx = longint'(qx) - (xc << FRAC_BITS);
		lz = longint'(qz) - (zc << FRAC_BITS);
		c   = center_store[xc * GRID_CELLS + zc];
		h00 = corner_store[xc * CORNER_SIDE + zc];
		h10 = corner_store[(xc + 1) * CORNER_SIDE + zc];
		h01 = corner_store[xc * CORNER_SIDE + zc + 1];
		h11 = corner_store[(xc + 1) * CORNER_SIDE + zc + 1];
		// Pick the triangle by the side of both diagonals the offset lies on.
		if (lx > lz) begin
			if (lz > UNIT - lx) begin
				base = h10; da = h11 - h10; u = lz; db = h10 + h11 - 2 * c; w = lx - UNIT;
			end else begin
				base = h00; da = h10 - h00; u = lx; db = 2 * c - h00 - h10; w = lz;
			end
		end else begin
			if (lz > UNIT - lx) begin
				base = h01; da = h11 - h01; u = lx; db = h01 + h11 - 2 * c; w = lz - UNIT;
			end else begin
				base = h00; da = h01 - h00; u = lz; db = 2 * c - h00 - h01; w = lx;
			end
		end
		acc = (base * UNIT + da * u + db * w) >>> FRAC_BITS;
		if (acc > HEIGHT_MAX)
			acc = HEIGHT_MAX;
		if (acc < HEIGHT_MIN)
			acc = HEIGHT_MIN;
		return acc[HOUT_W-1:0];
	endfunction

	// Update the predicted grids, or queue the height a query will return.
	function automatic void apply_request(hmtri_pkg::opcode_t op, hmtri_pkg::req_t r);
		case (op)
			hmtri_pkg::OP_WR_CENTER: begin
				if (r.grid_row < GRID_CELLS && r.grid_col < GRID_CELLS)
					center_store[r.grid_row * GRID_CELLS + r.grid_col] = r.height_in;
			end
			hmtri_pkg::OP_WR_CORNER: begin
				if (r.grid_row <= GRID_CELLS && r.grid_col <= GRID_CELLS)
					corner_store[r.grid_row * CORNER_SIDE + r.grid_col] = r.height_in;
			end
			hmtri_pkg::OP_QUERY:
				expected_heights = {expected_heights, predict_height(r.query_x, r.query_z)};
			default: ;
		endcase
	endfunction

	// Write request; the position fields carry junk the block must ignore.
	function automatic hmtri_pkg::req_t write_req(int unsigned row, int unsigned col,
			logic [HIN_W-1:0] h);
		hmtri_pkg::req_t r;
		r.grid_row  = row[INDEX_W-1:0];
		r.grid_col  = col[INDEX_W-1:0];
		r.height_in = h;
		r.query_x   = POS_W'($urandom);
		r.query_z   = POS_W'($urandom);
		return r;
	endfunction

	// Query request; the write fields carry junk the block must ignore.
	function automatic hmtri_pkg::req_t query_req(logic [POS_W-1:0] qx,
			logic [POS_W-1:0] qz);
		hmtri_pkg::req_t r;
		r.grid_row  = INDEX_W'($urandom);
		r.grid_col  = INDEX_W'($urandom);
		r.height_in = $urandom;
		r.query_x   = qx;
		r.query_z   = qz;
		return r;
	endfunction

	// Mostly full-range heights, with the extremes and small values mixed in.
	function automatic logic [HIN_W-1:0] random_height();
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3, 4: return $urandom_range(32'h001F_FFFF) - 32'h0010_0000;
			default: return $urandom;
		endcase
	endfunction

	// In-cell offset, often on the cell edges or its middle.
	function automatic int unsigned random_offset();
		case ($urandom_range(7))
			0: return 0;
			1: return 1;
			2: return 32'(UNIT / 2);
			3: return 32'(UNIT - 1);
			default: return $urandom_range(32'(UNIT - 1));
		endcase
	endfunction

	// Offer one request, idling first at random, and wait until it is taken.
	task automatic send_request(hmtri_pkg::opcode_t op, hmtri_pkg::req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= r;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		apply_request(op, r);
	endtask

	// Write the center and four corners of one cell, then allow queries on it.
	task automatic load_cell(int unsigned xc, int unsigned zc, logic [HIN_W-1:0] c,
			logic [HIN_W-1:0] h00, logic [HIN_W-1:0] h10, logic [HIN_W-1:0] h01,
			logic [HIN_W-1:0] h11);
		send_request(hmtri_pkg::OP_WR_CENTER, write_req(xc, zc, c));
		send_request(hmtri_pkg::OP_WR_CORNER, write_req(xc, zc, h00));
		send_request(hmtri_pkg::OP_WR_CORNER, write_req(xc + 1, zc, h10));
		send_request(hmtri_pkg::OP_WR_CORNER, write_req(xc, zc + 1, h01));
		send_request(hmtri_pkg::OP_WR_CORNER, write_req(xc + 1, zc + 1, h11));
		if (!cell_ready[xc * GRID_CELLS + zc]) begin
			cell_ready[xc * GRID_CELLS + zc] = 1'b1;
			ready_cells = {ready_cells, int'(xc * GRID_CELLS + zc)};
		end
	endtask

	// Query a random position in a fully written cell, or past it on the last row or column.
	task automatic query_ready_cell();
		int          cell_idx;
		int unsigned xc, zc, ox, oz;
		logic [POS_W-1:0] qx, qz;
		cell_idx = ready_cells[$urandom_range(ready_cells.size() - 1)];
		xc = cell_idx / GRID_CELLS;
		zc = cell_idx % GRID_CELLS;
		ox = random_offset();
		oz = random_offset();
		// Land on either diagonal now and then, where the triangle choice ties.
		case ($urandom_range(3))
			0: oz = ox;
			1: begin
				if (ox == 0)
					ox = 1;
				oz = 32'(UNIT) - ox;
			end
			default: ;
		endcase
		qx = POS_W'((xc << FRAC_BITS) + ox);
		qz = POS_W'((zc << FRAC_BITS) + oz);
		// On the last row or column, go anywhere past it to exercise clamping.
		if (xc == GRID_CELLS - 1 && $urandom_range(2) == 0)
			qx = POS_W'($urandom_range(24'hFF_FFFF, (GRID_CELLS - 1) << FRAC_BITS));
		if (zc == GRID_CELLS - 1 && $urandom_range(2) == 0)
			qz = POS_W'($urandom_range(24'hFF_FFFF, (GRID_CELLS - 1) << FRAC_BITS));
		send_request(hmtri_pkg::OP_QUERY, query_req(qx, qz));
	endtask

	task automatic report_error(string what, logic [HOUT_W-1:0] want,
			logic [HOUT_W-1:0] got);
		height_errors++;
		if (height_errors <= 10)
			$display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
	endtask

	// Stop offering requests and wait for every predicted height to come back.
	task automatic wait_for_results();
		int unsigned cycles;
		s_tvalid <= 1'b0;
		cycles = 0;
		while (expected_heights.size() != 0 && cycles < DRAIN_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		while (expected_heights.size() != 0)
			report_error("missing result", expected_heights.pop_front(), 'x);
	endtask

	// One cell with plain heights, queried once in each triangle and on both diagonals.
	task automatic test_triangle_choice();
		send_idle_pct = 0;
		load_cell(0, 0, 32'h0003_0000, 32'h0000_0000, 32'h0001_0000, 32'h0002_0000,
			32'hFFFF_0000);
		send_request(hmtri_pkg::OP_QUERY, query_req(24'h00_C000, 24'h00_2000));
		send_request(hmtri_pkg::OP_QUERY, query_req(24'h00_E000, 24'h00_8000));
		send_request(hmtri_pkg::OP_QUERY, query_req(24'h00_6000, 24'h00_E000));
		send_request(hmtri_pkg::OP_QUERY, query_req(24'h00_2000, 24'h00_6000));
		send_request(hmtri_pkg::OP_QUERY, query_req(24'h00_8000, 24'h00_8000));
		send_request(hmtri_pkg::OP_QUERY, query_req(24'h00_4000, 24'h00_C000));
		send_request(hmtri_pkg::OP_QUERY, query_req(24'h00_0000, 24'h00_0000));
		wait_for_results();
	endtask

	// The last cell with extreme heights, queried past the grid so most results saturate.
	task automatic test_clamp_and_saturation();
		load_cell(GRID_CELLS - 1, GRID_CELLS - 1, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_request(hmtri_pkg::OP_QUERY, query_req(24'hFF_FFFF, 24'hFF_FFFF));
		send_request(hmtri_pkg::OP_QUERY, query_req(24'hFF_FFFF, 24'h7F_0000));
		send_request(hmtri_pkg::OP_QUERY, query_req(24'h80_0000, 24'h7F_FFFF));
		wait_for_results();
	endtask

	// Writes outside the grids and the unused opcode must leave cell (0,0) alone.
	task automatic test_ignored_items();
		send_request(hmtri_pkg::OP_WR_CENTER, write_req(0, GRID_CELLS, 32'h1234_5678));
		send_request(hmtri_pkg::OP_WR_CORNER, write_req(0, GRID_CELLS + 1, 32'h7654_3210));
		send_request(hmtri_pkg::OP_WR_CORNER, write_req(255, 255, 32'hDEAD_BEEF));
		send_request(OP_UNUSED, write_req(0, 0, 32'h5555_AAAA));
		send_request(hmtri_pkg::OP_QUERY, query_req(24'h00_C000, 24'h00_2000));
		wait_for_results();
	endtask

	// Mostly cell loads and queries, with ignored and stray writes mixed in.
	task automatic test_random_traffic(int unsigned idle_pct, int unsigned stall_pct);
		int unsigned        counted, row, col;
		hmtri_pkg::opcode_t op;
		send_idle_pct = idle_pct;
		recv_stall_pct <= stall_pct;
		counted = 0;
		while (counted < PHASE_ITEMS) begin
			row = $urandom_range(255);
			col = $urandom_range(255);
			case ($urandom_range(19))
				0, 1: begin
					row = ($urandom_range(4) == 0) ? GRID_CELLS - 1 : $urandom_range(GRID_CELLS - 1);
					col = ($urandom_range(4) == 0) ? GRID_CELLS - 1 : $urandom_range(GRID_CELLS - 1);
					load_cell(row, col, random_height(), random_height(), random_height(),
						random_height(), random_height());
					counted += 5;
				end
				2: begin
					send_request(OP_UNUSED, write_req(row, col, $urandom));
					counted++;
				end
				3: begin
					if (row < GRID_CELLS && col < GRID_CELLS)
						row = $urandom_range(255, GRID_CELLS);
					send_request(hmtri_pkg::OP_WR_CENTER, write_req(row, col, $urandom));
					counted++;
				end
				4: begin
					if (row <= GRID_CELLS && col <= GRID_CELLS)
						col = $urandom_range(255, GRID_CELLS + 1);
					send_request(hmtri_pkg::OP_WR_CORNER, write_req(row, col, $urandom));
					counted++;
				end
				5: begin
					// A lone write, as if a cell load were cut short.
					op = $urandom_range(1) ? hmtri_pkg::OP_WR_CENTER : hmtri_pkg::OP_WR_CORNER;
					if (op == hmtri_pkg::OP_WR_CENTER)
						send_request(op, write_req(row % GRID_CELLS, col % GRID_CELLS,
							random_height()));
					else
						send_request(op, write_req(row % CORNER_SIDE, col % CORNER_SIDE,
							random_height()));
					counted++;
				end
				default: begin
					query_ready_cell();
					counted++;
				end
			endcase
		end
		wait_for_results();
	endtask

	// Hold results back long enough that the block fills and stops taking queries.
	task automatic test_result_backpressure();
		send_idle_pct = 0;
		recv_stall_pct <= 0;
		fork
			begin
				result_hold <= 1'b1;
				repeat (HOLD_CYCLES)
					@(posedge clk);
				result_hold <= 1'b0;
			end
		join_none
		for (int i = 0; i < 40; i++)
			query_ready_cell();
		wait_for_results();
	endtask

	// Result side: random stalls, or a forced hold-off.
	always @(posedge clk) begin
		m_tready <= !result_hold && ($urandom_range(99) >= recv_stall_pct);
	end

	// Compare each accepted result with the oldest predicted height.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_heights.size() == 0)
				report_error("unexpected result", 'x, m_tdata);
			else if (m_tdata !== expected_heights[0])
				report_error("height mismatch", expected_heights.pop_front(), m_tdata);
			else
				void'(expected_heights.pop_front());
		end
	end

	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = hmtri_pkg::OP_WR_CENTER;
		result_hold    = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		height_errors  = 0;
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_triangle_choice();
		test_clamp_and_saturation();
		test_ignored_items();
		test_random_traffic(0, 0);
		test_random_traffic(60, 0);
		test_random_traffic(0, 60);
		test_random_traffic(20, 20);
		test_result_backpressure();

		repeat (20)
			@(posedge clk);
		if (height_errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Safety net in case the block hangs.
	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
